>>> rtl/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions for the cell topology probability block
// Fixed-point format, lane and group geometry, and the record that travels
// along the chain of multiply cells.
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int CORNERS    = 8;
  localparam int CORNER_W   = 17;
  localparam int PROB_W     = 17;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 4;
  localparam int TOPOLOGIES = 256;
  localparam int GROUPS     = (TOPOLOGIES + LANES - 1) / LANES;
  localparam int GROUP_W    = 6;
  localparam int TOPO_W     = $clog2(GROUPS * LANES) + 1;
  localparam int PROD_W     = CORNER_W + PROB_W;

  localparam logic [CORNER_W-1:0] ONE        = CORNER_W'(1) << FRAC_BITS;
  localparam logic [GROUP_W-1:0]  LAST_GROUP = GROUP_W'(GROUPS - 1);

  typedef logic [CORNERS-1:0][CORNER_W-1:0] corner_vec_t;
  typedef logic [LANES-1:0][PROB_W-1:0]     prob_vec_t;

  // One group of topologies on its way through the multiply cells.
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic               last;
    corner_vec_t        corners;
    prob_vec_t          acc;
  } stage_t;

endpackage

>>> rtl/ctp_seq.sv
// ----------------------------------------------------------------------------
// ctp_seq: item capture and group issue
// Holds the saturated corners of the current cell and issues one group of
// topologies per cycle, while the chain advances, into the multiply chain.
// ----------------------------------------------------------------------------
module ctp_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cell_valid,
  output logic                 cell_stall,
  input  ctp_pkg::corner_vec_t corners,
  input  logic                 advance,
  output logic                 issue_valid,
  output ctp_pkg::stage_t      issue_stage
);
  import ctp_pkg::*;

  logic                busy;
  logic [GROUP_W-1:0]  count;
  corner_vec_t         held;
  logic                at_last;
  logic                accept;
  logic                issue;

  assign at_last    = (count == LAST_GROUP);
  assign cell_stall = busy && !(advance && at_last);
  assign accept     = cell_valid && !cell_stall;
  assign issue      = busy && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (accept) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (issue) begin
      if (at_last) begin
        busy  <= 1'b0;
        count <= '0;
      end else begin
        count <= count + GROUP_W'(1);
      end
    end
  end

  // Probabilities above one are clamped on capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int v = 0; v < CORNERS; v++) begin
        held[v] <= (corners[v] > ONE) ? ONE : corners[v];
      end
    end
  end

  always_comb begin
    logic [TOPO_W-1:0] t;
    issue_stage.group   = count;
    issue_stage.last    = at_last;
    issue_stage.corners = held;
    for (int l = 0; l < LANES; l++) begin
      t = TOPO_W'(count) * TOPO_W'(LANES) + TOPO_W'(l);
      // A lane past the last topology starts at zero and so stays zero.
      issue_stage.acc[l] = (t < TOPO_W'(TOPOLOGIES)) ? ONE : '0;
    end
  end

  assign issue_valid = busy;

endmodule

>>> rtl/ctp_cell.sv
// ----------------------------------------------------------------------------
// ctp_cell: one corner's multiply stage
// Multiplies every lane's running product by the corner probability or its
// complement, picked by the corner's bit of the lane's topology.
// ----------------------------------------------------------------------------
module ctp_cell #(
  parameter int CORNER_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            prev_valid,
  input  ctp_pkg::stage_t prev_stage,
  output logic            valid,
  output ctp_pkg::stage_t stage
);
  import ctp_pkg::*;

  stage_t stage_next;

  always_comb begin
    logic [TOPO_W-1:0]   t;
    logic [CORNER_W-1:0] p;
    logic [CORNER_W-1:0] factor;
    logic [PROD_W-1:0]   prod;
    stage_next = prev_stage;
    p = prev_stage.corners[CORNER_IDX];
    for (int l = 0; l < LANES; l++) begin
      t      = TOPO_W'(prev_stage.group) * TOPO_W'(LANES) + TOPO_W'(l);
      factor = t[CORNER_IDX] ? (ONE - p) : p;
      prod   = PROD_W'(prev_stage.acc[l]) * PROD_W'(factor);
      stage_next.acc[l] = prod[FRAC_BITS +: PROB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && prev_valid) begin
      stage <= stage_next;
    end
  end

endmodule

>>> rtl/cell_topology_probabilities.sv
// ----------------------------------------------------------------------------
// cell_topology_probabilities: topology probabilities of one cube cell
// Expands eight corner occupancy probabilities into the probabilities of all
// 256 corner-occupancy topologies, four topologies per result item.
// ----------------------------------------------------------------------------
// Usage. The input channel (cell_valid / cell_stall) takes one item holding
// the eight corner probabilities of a cell, in fixed point with 65536 = 1.0;
// values above one are treated as one. The output channel (group_valid /
// group_stall) gives 64 items per cell, group 0 first, each carrying four
// consecutive topology probabilities; last_group marks group 63.
// Throughput: one result item per cycle while group_stall is low. The
// next cell is taken in the same cycle as the previous cell's last group is
// issued, so cells follow one another without a gap. The rate is set by the
// single issue sequencer, which feeds one group per cycle into the chain while it advances.
// Path: the captured corners enter the first of eight cells in the cycle
// after acceptance, and each cell adds one register on the way to the
// output.
// Reset (rst, synchronous) empties the chain and the sequencer; any cell in
// progress is dropped. When group_stall is high with a result waiting, the
// whole chain and the sequencer hold, so cell_stall stays high for as long as
// the current cell still has groups left to issue.
// ----------------------------------------------------------------------------
module cell_topology_probabilities (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cell_valid,
  output logic                          cell_stall,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_0,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_1,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_2,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_3,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_4,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_5,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_6,
  input  logic [ctp_pkg::CORNER_W-1:0]  corner_7,
  output logic                          group_valid,
  input  logic                          group_stall,
  output logic [ctp_pkg::GROUP_W-1:0]   group_index,
  output logic [ctp_pkg::PROB_W-1:0]    prob_0,
  output logic [ctp_pkg::PROB_W-1:0]    prob_1,
  output logic [ctp_pkg::PROB_W-1:0]    prob_2,
  output logic [ctp_pkg::PROB_W-1:0]    prob_3,
  output logic                          last_group
);
  import ctp_pkg::*;

  corner_vec_t corners;
  logic        advance;
  logic        chain_valid [CORNERS+1];
  stage_t      chain_stage [CORNERS+1];

  assign corners = {corner_7, corner_6, corner_5, corner_4,
                    corner_3, corner_2, corner_1, corner_0};

  // The whole chain moves together unless a finished result is held back.
  assign advance = !(chain_valid[CORNERS] && group_stall);

  ctp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .corners     (corners),
    .advance     (advance),
    .issue_valid (chain_valid[0]),
    .issue_stage (chain_stage[0])
  );

  // One cell per corner; the final cell's register is the output register.
  for (genvar v = 0; v < CORNERS; v++) begin : g_cell
    ctp_cell #(
      .CORNER_IDX (v)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (chain_valid[v]),
      .prev_stage (chain_stage[v]),
      .valid      (chain_valid[v+1]),
      .stage      (chain_stage[v+1])
    );
  end

  assign group_valid = chain_valid[CORNERS];
  assign group_index = chain_stage[CORNERS].group;
  assign last_group  = chain_stage[CORNERS].last;
  assign prob_0      = chain_stage[CORNERS].acc[0];
  assign prob_1      = chain_stage[CORNERS].acc[1];
  assign prob_2      = chain_stage[CORNERS].acc[2];
  assign prob_3      = chain_stage[CORNERS].acc[3];

`ifndef SYNTHESIS
  // The last-group flag must travel with the final group number.
  a_last_matches_group: assert property (@(posedge clk) disable iff (rst)
    group_valid |-> (last_group == (group_index == LAST_GROUP)))
    else $error("last_group flag does not match group_index");

  // A product of factors no greater than one can never exceed one.
  a_prob_in_range: assert property (@(posedge clk) disable iff (rst)
    group_valid |-> (prob_0 <= ONE && prob_1 <= ONE && prob_2 <= ONE && prob_3 <= ONE))
    else $error("topology probability above one");

  // An accepted cell must start issuing groups in the next cycle.
  a_accept_starts_issue: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall |=> chain_valid[0] && chain_stage[0].group == '0)
    else $error("accepted cell did not start at group zero");
`endif

endmodule
